[rtl/fru_pkg.sv]
package fru_pkg;

	// frame geometry
	localparam int RAW_WORDS = 32;
	localparam int MAX_ROWS  = 64;
	localparam int ROW_LIM   = (MAX_ROWS < 64) ? MAX_ROWS : 64;

	// field and register widths
	localparam int WORD_W  = 32;
	localparam int ACC_W   = 64;
	localparam int BPR_W   = 6;
	localparam int SKIP_W  = 5;
	localparam int RCNT_W  = 7;
	localparam int FILL_W  = 7;
	localparam int IDX_W   = 6;
	localparam int WORDS_W = (RAW_WORDS > 1) ? $clog2(RAW_WORDS) : 1;
	localparam int CFG_W   = 7;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_BITS_PER_ROW = 2'd0,
		CFG_SKIP_BITS    = 2'd1,
		CFG_ROW_COUNT    = 2'd2
	} cfg_idx_t;

	// control of the shared shifter
	typedef struct packed {
		logic             left;
		logic [BPR_W-1:0] amount;
	} shift_ctrl_t;

endpackage

[rtl/fru_shifter.sv]
module fru_shifter (
	input  fru_pkg::shift_ctrl_t            ctrl,
	input  logic [fru_pkg::ACC_W-1:0]       din,
	output logic [fru_pkg::ACC_W-1:0]       dout
);
	import fru_pkg::*;

	// one barrel shifter, left for word insertion, right for row removal
	always_comb begin
		if (ctrl.left) begin
			dout = din << ctrl.amount;
		end else begin
			dout = din >> ctrl.amount;
		end
	end

endmodule

[rtl/fuse_row_unpacker_top.sv]
// fuse row unpacker: re-slices packed 32-bit fuse words into rows
// flow: a word is taken in S_IDLE and merged in the cycle after, in S_MERGE;
//   S_EMIT then hands out the rows it completes, one per cycle while the
//   output is free, and a new word is taken only back in S_IDLE; all through
//   one shared 64-bit shifter; the last word of a frame flushes every
//   remaining row, one per cycle while the output is free, up to 64 rows
// reset: asynchronous, clears the frame state and loads the register defaults
module fuse_row_unpacker_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  fru_pkg::cfg_idx_t               cfg_index,
	input  logic [fru_pkg::CFG_W-1:0]       cfg_data,
	// raw word channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fru_pkg::WORD_W-1:0]      raw_word,
	// row channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fru_pkg::WORD_W-1:0]      row_value,
	output logic [fru_pkg::IDX_W-1:0]       row_index,
	output logic                            last_row
);
	import fru_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MERGE,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [BPR_W-1:0]       bpr_q;
	logic [SKIP_W-1:0]      skip_q;
	logic [RCNT_W-1:0]      rcnt_q;
	logic [ACC_W-1:0]       acc_q;
	logic [FILL_W-1:0]      fill_q;
	logic [WORDS_W-1:0]     words_q;
	logic [RCNT_W-1:0]      rows_q;
	logic [WORD_W-1:0]      word_q;
	logic                   last_q;
	logic                   out_valid_q;
	logic [WORD_W-1:0]      row_value_q;
	logic [IDX_W-1:0]       row_index_q;
	logic                   last_row_q;

	logic [BPR_W-1:0]       width;
	logic [RCNT_W-1:0]      nrows;
	logic                   rows_open;
	logic                   emit_ok;
	logic                   slot_free;
	logic [FILL_W-1:0]      fill_merge;
	logic [ACC_W-1:0]       acc_merge;
	logic [ACC_W-1:0]       fill_mask;
	logic [WORD_W-1:0]      row_mask;
	logic [FILL_W-1:0]      fill_next;
	shift_ctrl_t            sh_ctrl;
	logic [ACC_W-1:0]       sh_din;
	logic [ACC_W-1:0]       sh_dout;

	// effective row width and row count
	always_comb begin
		priority if (bpr_q == '0) begin
			width = BPR_W'(1);
		end else if (bpr_q > BPR_W'(WORD_W)) begin
			width = BPR_W'(WORD_W);
		end else begin
			width = bpr_q;
		end
		if (rcnt_q > RCNT_W'(ROW_LIM)) begin
			nrows = RCNT_W'(ROW_LIM);
		end else begin
			nrows = rcnt_q;
		end
	end

	assign rows_open = (rows_q < nrows);
	assign emit_ok   = rows_open && ((fill_q >= FILL_W'(width)) || last_q);
	assign slot_free = !out_valid_q || out_ready;

	// shared shifter: insert word at the fill point, or drop one row
	always_comb begin
		if (state_q == S_MERGE) begin
			sh_ctrl.left   = 1'b1;
			sh_ctrl.amount = BPR_W'(fill_q[SKIP_W-1:0]);
			sh_din         = ACC_W'(word_q);
		end else begin
			sh_ctrl.left   = 1'b0;
			sh_ctrl.amount = width;
			sh_din         = acc_q;
		end
	end

	fru_shifter u_shifter (
		.ctrl (sh_ctrl),
		.din  (sh_din),
		.dout (sh_dout)
	);

	// merge: new fill level, top bits dropped on the last word of a frame
	always_comb begin
		if (last_q) begin
			fill_merge = fill_q + FILL_W'(WORD_W) - FILL_W'(skip_q);
		end else begin
			fill_merge = fill_q + FILL_W'(WORD_W);
		end
		fill_mask = ~({ACC_W{1'b1}} << fill_merge[$clog2(ACC_W)-1:0]);
		acc_merge = acc_q | sh_dout;
		if (last_q) begin
			acc_merge = acc_merge & fill_mask;
		end
	end

	// row extraction
	assign row_mask  = ~({WORD_W{1'b1}} << width);
	assign fill_next = (fill_q > FILL_W'(width)) ? (fill_q - FILL_W'(width)) : '0;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign row_value = row_value_q;
	assign row_index = row_index_q;
	assign last_row  = last_row_q;

	// sequencer, frame state, output word register and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bpr_q       <= BPR_W'(25);
			skip_q      <= '0;
			rcnt_q      <= RCNT_W'(42);
			acc_q       <= '0;
			fill_q      <= '0;
			words_q     <= '0;
			rows_q      <= '0;
			word_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			row_value_q <= '0;
			row_index_q <= '0;
			last_row_q  <= 1'b0;
		end else begin
			// drop the word once taken, unless a new row replaces it
			if (out_valid_q && out_ready && !(state_q == S_EMIT && emit_ok)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						word_q  <= raw_word;
						last_q  <= (words_q == WORDS_W'(RAW_WORDS - 1));
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					// once all rows are out, the word's bits are discarded
					if (rows_open) begin
						acc_q  <= acc_merge;
						fill_q <= fill_merge;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							row_value_q <= acc_q[WORD_W-1:0] & row_mask;
							row_index_q <= rows_q[IDX_W-1:0];
							last_row_q  <= (rows_q + RCNT_W'(1) == nrows);
							acc_q       <= sh_dout;
							fill_q      <= fill_next;
							rows_q      <= rows_q + RCNT_W'(1);
						end
					end else begin
						if (last_q) begin
							acc_q   <= '0;
							fill_q  <= FILL_W'(skip_q);
							words_q <= '0;
							rows_q  <= '0;
						end else begin
							words_q <= words_q + WORDS_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// config writes arrive only while the block is idle
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_BITS_PER_ROW: begin
						bpr_q <= cfg_data[BPR_W-1:0];
					end
					CFG_SKIP_BITS: begin
						skip_q <= cfg_data[SKIP_W-1:0];
						if (words_q == '0 && rows_q == '0) begin
							fill_q <= FILL_W'(cfg_data[SKIP_W-1:0]);
						end
					end
					CFG_ROW_COUNT: begin
						rcnt_q <= cfg_data[RCNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
